### hdl/fnso_pkg.sv
`timescale 1ns / 1ps

package fnso_pkg;

  localparam int MAX_SIDE        = 4096;
  localparam int NUMBER_BITS_DEF = 32;
  localparam int COORD_W         = $clog2(MAX_SIDE);
  localparam int CFG_W           = 13;
  localparam int PIX_W           = 16;
  localparam int FRAME_W         = 32;
  localparam int BIT_IDX_W       = $clog2(FRAME_W);
  localparam int REM_STEPS       = 8;
  localparam int REM_STAGES      = FRAME_W / REM_STEPS;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL = 3'd5;

  typedef enum logic [1:0] {
    MARK_PASS   = 2'd0,
    MARK_BLOCK  = 2'd1,
    MARK_MARKER = 2'd2
  } mark_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_in;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [FRAME_W-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    mark_kind_t       mark_kind;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] num_cols;
    logic [CFG_W-1:0] num_rows;
    logic [CFG_W-1:0] block_size;
    logic [CFG_W-1:0] marker_size;
    logic [PIX_W-1:0] dark_level;
    logic [PIX_W-1:0] bright_level;
  } cfg_t;

  typedef struct packed {
    logic             marker_ok;
    logic [CFG_W-1:0] marker_top;
    logic [CFG_W-1:0] travel;
  } geom_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_in;
    logic [COORD_W-1:0] column;
    logic               marker_row;
    logic               block_hit;
    logic               block_bit;
  } side_t;

  typedef struct packed {
    logic [FRAME_W-1:0] product;
    logic [CFG_W-1:0]   rem;
    side_t              side;
  } rem_item_t;

endpackage

### hdl/fnso_regs.sv
`timescale 1ns / 1ps

module fnso_regs
  import fnso_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data,
  output cfg_t                 cfg,
  output geom_t                geom
);

  logic [CFG_W:0] marker_twice;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_cols     <= CFG_W'(2048);
      cfg.num_rows     <= CFG_W'(2048);
      cfg.block_size   <= CFG_W'(32);
      cfg.marker_size  <= CFG_W'(170);
      cfg.dark_level   <= '0;
      cfg.bright_level <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUM_COLS:     cfg.num_cols     <= cfg_data[CFG_W-1:0];
        REG_NUM_ROWS:     cfg.num_rows     <= cfg_data[CFG_W-1:0];
        REG_BLOCK_SIZE:   cfg.block_size   <= cfg_data[CFG_W-1:0];
        REG_MARKER_SIZE:  cfg.marker_size  <= cfg_data[CFG_W-1:0];
        REG_DARK_LEVEL:   cfg.dark_level   <= cfg_data;
        REG_BRIGHT_LEVEL: cfg.bright_level <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    marker_twice    = {cfg.marker_size, 1'b0};
    geom.marker_ok  = (cfg.marker_size != '0) && (cfg.num_cols > cfg.marker_size) &&
                      ({1'b0, cfg.num_rows} > marker_twice);
    geom.marker_top = cfg.num_rows - marker_twice[CFG_W-1:0];
    geom.travel     = cfg.num_cols - cfg.marker_size;
  end

endmodule

### hdl/fnso_front.sv
`timescale 1ns / 1ps

module fnso_front
  import fnso_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  geom_t     geom,
  input  logic      up_valid,
  output logic      up_ready,
  input  in_item_t  up_data,
  output logic      down_valid,
  input  logic      down_ready,
  output rem_item_t down_data
);

  localparam int QW = (NUMBER_BITS > 1) ? $clog2(NUMBER_BITS) : 1;
  localparam int DW = CFG_W + QW;

  logic [DW-1:0]        span;
  logic [DW-1:0]        part;
  logic [QW-1:0]        quo;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic [COORD_W:0]     row_off;
  logic [FRAME_W-1:0]   step;
  logic                 in_frame;
  rem_item_t            item_next;

  always_comb begin
    span = DW'(cfg.block_size) * DW'(NUMBER_BITS);
    part = DW'(up_data.column);
    quo  = '0;
    for (int k = QW - 1; k >= 0; k--) begin
      if (part >= (DW'(cfg.block_size) << k)) begin
        part   = part - (DW'(cfg.block_size) << k);
        quo[k] = 1'b1;
      end
    end
    bit_idx  = BIT_IDX_W'(NUMBER_BITS - 1) - BIT_IDX_W'(quo);
    in_frame = ({1'b0, up_data.column} < cfg.num_cols) &&
               ({1'b0, up_data.row} < cfg.num_rows);
    row_off  = {1'b0, up_data.row} - geom.marker_top;

    step = FRAME_W'({1'b0, cfg.marker_size[CFG_W-1:2]}) + FRAME_W'(1);

    item_next.product         = up_data.frame_number * step;
    item_next.rem             = '0;
    item_next.side.pixel_in   = up_data.pixel_in;
    item_next.side.column     = up_data.column;
    item_next.side.marker_row = in_frame && geom.marker_ok &&
                                ({1'b0, up_data.row} >= geom.marker_top) &&
                                (row_off < cfg.marker_size);
    item_next.side.block_hit  = in_frame && (cfg.block_size != '0) &&
                                ({1'b0, up_data.row} < cfg.block_size) &&
                                (DW'(up_data.column) < span);
    item_next.side.block_bit  = up_data.frame_number[bit_idx];
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_data <= item_next;
    end
  end

endmodule

### hdl/fnso_rem_stage.sv
`timescale 1ns / 1ps

module fnso_rem_stage
  import fnso_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  geom_t     geom,
  input  logic      up_valid,
  output logic      up_ready,
  input  rem_item_t up_data,
  output logic      down_valid,
  input  logic      down_ready,
  output rem_item_t down_data
);

  logic [CFG_W:0]   trial;
  logic [CFG_W-1:0] rem;
  logic [FRAME_W-1:0] prod;
  rem_item_t        item_next;

  // Each step brings down the next product bit; the remainder stays below the travel.
  always_comb begin
    rem  = up_data.rem;
    prod = up_data.product;
    for (int k = 0; k < REM_STEPS; k++) begin
      trial = {rem, prod[FRAME_W-1]};
      prod  = prod << 1;
      if (trial >= {1'b0, geom.travel}) begin
        rem = CFG_W'(trial - {1'b0, geom.travel});
      end else begin
        rem = trial[CFG_W-1:0];
      end
    end
    item_next         = up_data;
    item_next.product = prod;
    item_next.rem     = rem;
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_data <= item_next;
    end
  end

endmodule

### hdl/fnso_select.sv
`timescale 1ns / 1ps

module fnso_select
  import fnso_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  rem_item_t up_data,
  output logic      down_valid,
  input  logic      down_ready,
  output out_item_t down_data
);

  logic [CFG_W-1:0] col_ext;
  logic [CFG_W-1:0] col_off;
  logic             col_hit;
  out_item_t        item_next;

  always_comb begin
    col_ext = {1'b0, up_data.side.column};
    col_off = col_ext - up_data.rem;
    col_hit = (col_ext >= up_data.rem) && (col_off < cfg.marker_size);
    if (up_data.side.marker_row && col_hit) begin
      item_next.pixel_out = cfg.bright_level;
      item_next.mark_kind = MARK_MARKER;
    end else if (up_data.side.block_hit) begin
      item_next.pixel_out = up_data.side.block_bit ? cfg.bright_level : cfg.dark_level;
      item_next.mark_kind = MARK_BLOCK;
    end else begin
      item_next.pixel_out = up_data.side.pixel_in;
      item_next.mark_kind = MARK_PASS;
    end
  end

  assign up_ready = !down_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      down_data <= item_next;
    end
  end

endmodule

### hdl/frame_number_stamp_overlay.sv
`timescale 1ns / 1ps

// Stamps a frame number as a row of square blocks along the top of a frame and
// draws a moving square marker near the bottom, one pixel per transaction.
// Input channel in_valid/in_ready/in_data carries a pixel with its column, row
// and frame number; output channel out_valid/out_ready/out_data returns the
// overlaid pixel and the kind of mark applied to it.
// Configuration writes arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. The user must make writes only while no
// pixel is in flight; the block itself does not enforce this.
// Throughput is one pixel per clock while the output is not stalled. The
// marker position is reduced by a remainder pipeline of four stages, eight
// bits each, behind a multiply and block index stage.
// Each stage holds its item while the next one is full, so a stall at the
// output fills the bubbles first and then lowers in_ready; nothing is lost
// or repeated.
// Synchronous reset empties the pipeline and loads the default register set.

module frame_number_stamp_overlay
  import fnso_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  cfg_t      cfg;
  geom_t     geom;
  logic      link_valid [REM_STAGES+1];
  logic      link_ready [REM_STAGES+1];
  rem_item_t link_data  [REM_STAGES+1];

  fnso_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .geom      (geom)
  );

  fnso_front #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .geom       (geom),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .up_data    (in_data),
    .down_valid (link_valid[0]),
    .down_ready (link_ready[0]),
    .down_data  (link_data[0])
  );

  for (genvar g = 0; g < REM_STAGES; g++) begin : g_rem
    fnso_rem_stage u_rem (
      .clk        (clk),
      .rst        (rst),
      .geom       (geom),
      .up_valid   (link_valid[g]),
      .up_ready   (link_ready[g]),
      .up_data    (link_data[g]),
      .down_valid (link_valid[g+1]),
      .down_ready (link_ready[g+1]),
      .down_data  (link_data[g+1])
    );
  end

  fnso_select u_select (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (link_valid[REM_STAGES]),
    .up_ready   (link_ready[REM_STAGES]),
    .up_data    (link_data[REM_STAGES]),
    .down_valid (out_valid),
    .down_ready (out_ready),
    .down_data  (out_data)
  );

endmodule
